>>> src/bpa_pkg.sv
// bpa_pkg: shared constants, codes and word types of the bitmap page allocator
// used by every module under src except bpa_ram

package bpa_pkg;

    // map geometry
    localparam int MAP_WORDS  = 512;
    localparam int PAGE_BYTES = 4096;
    localparam int WORD_BITS  = 32;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int WORD_AW    = $clog2(MAP_WORDS);
    localparam int WCNT_W     = WORD_AW + 1;
    localparam int CAP_PAGES  = MAP_WORDS * WORD_BITS;
    localparam int PGN_W      = WORD_AW + BIT_W;
    localparam int CAP_W      = PGN_W + 1;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

    // field widths
    localparam int OP_W     = 2;
    localparam int ADDR_W   = 26;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 15;
    localparam int FPG_W    = ADDR_W - PAGE_SHIFT;

    // configuration port
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 1'b1;

    localparam logic [CNT_W-1:0] TOTAL_RST    = 15'd16384;
    localparam logic [CNT_W-1:0] RESERVED_RST = 15'd1024;
    localparam logic [CNT_W-1:0] CNT_MAX      = '1;

    // state after reset, as after an init with the reset register values
    localparam int T_RST   = (int'(TOTAL_RST) < CAP_PAGES) ? int'(TOTAL_RST) : CAP_PAGES;
    localparam int R_RST   = (int'(RESERVED_RST) < CAP_PAGES) ? int'(RESERVED_RST) : CAP_PAGES;
    localparam int CNT_RST = (T_RST > int'(RESERVED_RST)) ? (T_RST - int'(RESERVED_RST)) : 0;

    // op codes
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_INIT  = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OOM       = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] page_address;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   alloc_address;
        logic [CNT_W-1:0]    free_count;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic                accept;
        logic                init_start;
        logic                init_step;
        logic                scan_start;
        logic                scan_step;
        logic                alloc_commit;
        logic                free_rd;
        logic                free_commit;
        logic                res_load;
        logic [STATUS_W-1:0] res_status;
        logic                rsp_load;
    } ctl_t;

    // datapath to controller
    typedef struct packed {
        logic init_last;
        logic scan_empty;
        logic hit;
        logic scan_last;
        logic free_oor;
        logic free_set;
        logic out_free;
    } sts_t;

endpackage

>>> src/bitmap_page_allocator.sv
// First-fit physical page allocator over a one-bit-per-page used map held in a
// MAP_WORDS x 32 ram. One word at a time: alloc reads one map word per cycle
// through the ram read port, and a hit stops the scan early; free reads the map
// word of the page and clears its bit if set, then hands off the result; init
// writes one map word per cycle. After reset the block runs the same clearing
// pass (req_stall high, no result word); configuration writes are taken at any
// time. A result word waits in an output register, so the next request can enter
// while it is stalled.
// depends on bpa_pkg, bpa_ctrl, bpa_datapath

module bitmap_page_allocator
    import bpa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0]     cfg_data,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  req_t                 req,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output rsp_t                 rsp
);

    ctl_t ctl;
    sts_t sts;

    assign cfg_ready = 1'b1;

    bpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_op    (req.op),
        .req_stall (req_stall),
        .sts       (sts),
        .ctl       (ctl)
    );

    bpa_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .ctl       (ctl),
        .sts       (sts),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

>>> src/bpa_ram.sv
// bpa_ram: generic single-clock ram, one write port and one registered read port
// no package dependencies

module bpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/bpa_datapath.sv
// bpa_datapath: config registers, used map ram, free counter, scan and result registers
// depends on bpa_pkg and bpa_ram

module bpa_datapath
    import bpa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0]     cfg_data,
    input  req_t                 req,
    input  ctl_t                 ctl,
    output sts_t                 sts,
    input  logic                 rsp_stall,
    output logic                 rsp_valid,
    output rsp_t                 rsp
);

    logic [CNT_W-1:0]   total_reg;
    logic [CNT_W-1:0]   reserved_reg;
    logic [CAP_W-1:0]   rlat_reg;
    logic [CAP_W-1:0]   rlat_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [WCNT_W-1:0]  wcnt_reg;
    logic [WCNT_W-1:0]  wcnt_next;
    logic               rdv_reg;
    logic               rdv_next;
    logic [WORD_AW-1:0] rdw_reg;
    logic [WORD_AW-1:0] rdw_next;
    logic [ADDR_W-1:0]  addr_reg;
    rsp_t               res_reg;
    rsp_t               res_next;
    rsp_t               rsp_reg;
    logic               rsp_valid_reg;

    logic [CAP_W-1:0]     teff;
    logic [WCNT_W-1:0]    nwords;
    logic [WCNT_W-1:0]    tword;
    logic [BIT_W-1:0]     tbit;
    logic [WCNT_W-1:0]    rword;
    logic [BIT_W-1:0]     rbit;
    logic [CNT_W-1:0]     cnt_init;
    logic [WORD_BITS-1:0] init_pat;
    logic [WORD_BITS-1:0] vmask;
    logic [WORD_BITS-1:0] free_bits;
    logic [BIT_W-1:0]     hit_bit;
    logic [PGN_W-1:0]     hit_page;
    logic [ADDR_W-1:0]    hit_addr;
    logic [FPG_W-1:0]     fpg;
    logic [PGN_W-1:0]     fpage;
    logic                 scan_issue;

    logic                 ram_we;
    logic [WORD_AW-1:0]   ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic                 ram_re;
    logic [WORD_AW-1:0]   ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    function automatic logic [WORD_BITS-1:0] low_mask(input logic [BIT_W-1:0] n);
        return (WORD_BITS'(1) << n) - WORD_BITS'(1);
    endfunction

    // effective totals clamped to the map size
    assign teff   = (32'(total_reg) < CAP_PAGES) ? CAP_W'(total_reg) : CAP_W'(CAP_PAGES);
    assign nwords = WCNT_W'((teff + CAP_W'(WORD_BITS - 1)) >> BIT_W);
    assign tword  = WCNT_W'(teff >> BIT_W);
    assign tbit   = teff[BIT_W-1:0];
    assign rword  = WCNT_W'(rlat_reg >> BIT_W);
    assign rbit   = rlat_reg[BIT_W-1:0];

    assign rlat_next = (32'(reserved_reg) < CAP_PAGES) ? CAP_W'(reserved_reg)
                                                       : CAP_W'(CAP_PAGES);
    assign cnt_init  = (32'(teff) > 32'(reserved_reg))
                     ? CNT_W'(32'(teff) - 32'(reserved_reg)) : '0;

    // init word pattern: whole words of reserved pages, then a partial word
    always_comb
    begin
        if (wcnt_reg < rword)
        begin
            init_pat = '1;
        end
        else if (wcnt_reg == rword)
        begin
            init_pat = low_mask(rbit);
        end
        else
        begin
            init_pat = '0;
        end
    end

    // pages of the word under test that lie below the total
    always_comb
    begin
        if (WCNT_W'(rdw_reg) < tword)
        begin
            vmask = '1;
        end
        else if (WCNT_W'(rdw_reg) == tword)
        begin
            vmask = low_mask(tbit);
        end
        else
        begin
            vmask = '0;
        end
    end

    assign free_bits = vmask & ~ram_rdata;

    // lowest clear page in the word
    always_comb
    begin
        hit_bit = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (free_bits[i])
            begin
                hit_bit = BIT_W'(i);
            end
        end
    end

    assign hit_page = {rdw_reg, hit_bit};
    assign hit_addr = ADDR_W'(64'(hit_page) << PAGE_SHIFT);

    assign fpg   = addr_reg[ADDR_W-1:PAGE_SHIFT];
    assign fpage = PGN_W'(fpg);

    assign scan_issue = ctl.scan_step && (wcnt_reg < nwords);

    // map ram ports
    always_comb
    begin
        ram_we    = ctl.init_step || ctl.alloc_commit || ctl.free_commit;
        ram_waddr = wcnt_reg[WORD_AW-1:0];
        ram_wdata = init_pat;
        if (ctl.alloc_commit)
        begin
            ram_waddr = rdw_reg;
            ram_wdata = ram_rdata | (WORD_BITS'(1) << hit_bit);
        end
        else if (ctl.free_commit)
        begin
            ram_waddr = fpage[PGN_W-1:BIT_W];
            ram_wdata = ram_rdata & ~(WORD_BITS'(1) << fpage[BIT_W-1:0]);
        end
        ram_re    = scan_issue || ctl.free_rd;
        ram_raddr = ctl.free_rd ? fpage[PGN_W-1:BIT_W] : wcnt_reg[WORD_AW-1:0];
    end

    bpa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // word counter and read tracking
    always_comb
    begin
        wcnt_next = wcnt_reg;
        rdv_next  = rdv_reg;
        rdw_next  = rdw_reg;
        if (ctl.init_start || ctl.scan_start)
        begin
            wcnt_next = '0;
            rdv_next  = 1'b0;
        end
        else if (ctl.init_step)
        begin
            wcnt_next = wcnt_reg + WCNT_W'(1);
        end
        else if (ctl.scan_step)
        begin
            rdv_next = scan_issue;
            if (scan_issue)
            begin
                wcnt_next = wcnt_reg + WCNT_W'(1);
                rdw_next  = wcnt_reg[WORD_AW-1:0];
            end
        end
    end

    // free counter, saturating both ways
    always_comb
    begin
        cnt_next = cnt_reg;
        if (ctl.init_start)
        begin
            cnt_next = cnt_init;
        end
        else if (ctl.alloc_commit)
        begin
            if (cnt_reg != '0)
            begin
                cnt_next = cnt_reg - CNT_W'(1);
            end
        end
        else if (ctl.free_commit)
        begin
            if (cnt_reg != CNT_MAX)
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_comb
    begin
        res_next.status        = ctl.res_status;
        res_next.alloc_address = ctl.alloc_commit ? hit_addr : '0;
        res_next.free_count    = cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= TOTAL_RST;
            reserved_reg  <= RESERVED_RST;
            rlat_reg      <= CAP_W'(R_RST);
            cnt_reg       <= CNT_W'(CNT_RST);
            wcnt_reg      <= '0;
            rdv_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_TOTAL:    total_reg    <= cfg_data;
                    CFG_RESERVED: reserved_reg <= cfg_data;
                    default:      ;
                endcase
            end
            if (ctl.init_start)
            begin
                rlat_reg <= rlat_next;
            end
            cnt_reg  <= cnt_next;
            wcnt_reg <= wcnt_next;
            rdv_reg  <= rdv_next;
            if (ctl.rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rdw_reg <= rdw_next;
        if (ctl.accept)
        begin
            addr_reg <= req.page_address;
        end
        if (ctl.res_load)
        begin
            res_reg <= res_next;
        end
        if (ctl.rsp_load)
        begin
            rsp_reg <= res_reg;
        end
    end

    always_comb
    begin
        sts.init_last  = (wcnt_reg == WCNT_W'(MAP_WORDS - 1));
        sts.scan_empty = (nwords == '0);
        sts.hit        = rdv_reg && (free_bits != '0);
        sts.scan_last  = rdv_reg && (WCNT_W'(rdw_reg) == nwords - WCNT_W'(1));
        sts.free_oor   = (32'(fpg) >= 32'(teff));
        sts.free_set   = ram_rdata[fpage[BIT_W-1:0]];
        sts.out_free   = !rsp_valid_reg || !rsp_stall;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> src/bpa_ctrl.sv
// bpa_ctrl: operation sequencer of the page allocator
// depends on bpa_pkg; drives the datapath through ctl_t and reads sts_t

module bpa_ctrl
    import bpa_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  logic [OP_W-1:0] req_op,
    output logic            req_stall,
    input  sts_t            sts,
    output ctl_t            ctl
);

    typedef enum logic [6:0] {
        S_BOOT     = 7'b0000001,
        S_IDLE     = 7'b0000010,
        S_SCAN     = 7'b0000100,
        S_FREE_RD  = 7'b0001000,
        S_FREE_CHK = 7'b0010000,
        S_INIT     = 7'b0100000,
        S_RESP     = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        ctl.res_status = ST_OK;
        case (state_reg)
            S_BOOT:
            begin
                // clearing pass after reset, no word produced
                ctl.init_step = 1'b1;
                if (sts.init_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    ctl.accept = 1'b1;
                    case (req_op)
                        OP_ALLOC:
                        begin
                            if (sts.scan_empty)
                            begin
                                ctl.res_load   = 1'b1;
                                ctl.res_status = ST_OOM;
                                state_next     = S_RESP;
                            end
                            else
                            begin
                                ctl.scan_start = 1'b1;
                                state_next     = S_SCAN;
                            end
                        end
                        OP_FREE:
                        begin
                            state_next = S_FREE_RD;
                        end
                        OP_INIT:
                        begin
                            ctl.init_start = 1'b1;
                            state_next     = S_INIT;
                        end
                        default:
                        begin
                            ctl.res_load = 1'b1;
                            state_next   = S_RESP;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (sts.hit)
                begin
                    ctl.alloc_commit = 1'b1;
                    ctl.res_load     = 1'b1;
                    state_next       = S_RESP;
                end
                else if (sts.scan_last)
                begin
                    ctl.res_load   = 1'b1;
                    ctl.res_status = ST_OOM;
                    state_next     = S_RESP;
                end
                else
                begin
                    ctl.scan_step = 1'b1;
                end
            end
            S_FREE_RD:
            begin
                if (sts.free_oor)
                begin
                    ctl.res_load   = 1'b1;
                    ctl.res_status = ST_RANGE;
                    state_next     = S_RESP;
                end
                else
                begin
                    ctl.free_rd = 1'b1;
                    state_next  = S_FREE_CHK;
                end
            end
            S_FREE_CHK:
            begin
                ctl.res_load = 1'b1;
                if (sts.free_set)
                begin
                    ctl.free_commit = 1'b1;
                end
                else
                begin
                    ctl.res_status = ST_NOT_ALLOC;
                end
                state_next = S_RESP;
            end
            S_INIT:
            begin
                ctl.init_step = 1'b1;
                if (sts.init_last)
                begin
                    ctl.res_load = 1'b1;
                    state_next   = S_RESP;
                end
            end
            S_RESP:
            begin
                if (sts.out_free)
                begin
                    ctl.rsp_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_BOOT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);

endmodule
